### hdl/clcd_pkg.sv
// Shared types, codes and the control program of the character display shadow buffer.
// Used by the datapath, the sequencer and the top level; depends on nothing.
package clcd_pkg;

    localparam logic [2:0] MODE_SETCUR = 3'd0;
    localparam logic [2:0] MODE_PRINT  = 3'd1;
    localparam logic [2:0] MODE_WRCELL = 3'd2;
    localparam logic [2:0] MODE_CLEAR  = 3'd3;
    localparam logic [2:0] MODE_UPDATE = 3'd4;

    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_CELL   = 2'd1;
    localparam logic [1:0] KIND_EMPTY  = 2'd2;

    localparam logic [6:0] SPACE_CHAR = 7'h20;

    typedef struct packed {
        logic [2:0] mode;
        logic [6:0] column;
        logic [2:0] line;
        logic [6:0] char_code;
        logic       force_req;
    } t_in_item;

    typedef struct packed {
        logic [1:0] kind;
        logic       status;
        logic       move_cursor;
        logic [2:0] panel;
        logic [4:0] panel_column;
        logic [2:0] row;
        logic [6:0] glyph;
        logic       last;
    } t_out_item;

    typedef enum logic [3:0] {
        U_FETCH,
        U_SETCUR,
        U_PRINT,
        U_WRCELL,
        U_CELL_RD,
        U_CELL_PUT,
        U_CLEAR,
        U_STATUS,
        U_SCAN_INIT,
        U_SCAN_RD,
        U_SCAN_EVAL,
        U_SCAN_END
    } t_upc;

    typedef enum logic [3:0] {
        OP_ACCEPT,
        OP_SETCUR,
        OP_ADDR_CUR,
        OP_ADDR_TGT,
        OP_CELL_RD,
        OP_CELL_PUT,
        OP_CLEAR,
        OP_STATUS,
        OP_SCAN_INIT,
        OP_SCAN_RD,
        OP_SCAN_EVAL,
        OP_SCAN_END
    } t_uop;

    typedef enum logic [1:0] {
        SEQ_NEXT,
        SEQ_DISPATCH,
        SEQ_LOOP
    } t_useq;

    typedef struct packed {
        t_uop  op;
        t_useq seq;
        t_upc  nxt_pc;
        t_upc  alt_pc;
    } t_uword;

    typedef struct packed {
        logic       hold;
        logic       accept;
        logic       last_cell;
        logic [2:0] mode;
    } t_dp_stat;

    function automatic t_uword f_ucode(input t_upc pc);
        t_uword w;
        unique case (pc)
            U_FETCH:     w = '{op: OP_ACCEPT,    seq: SEQ_DISPATCH, nxt_pc: U_FETCH,
                               alt_pc: U_FETCH};
            U_SETCUR:    w = '{op: OP_SETCUR,    seq: SEQ_NEXT, nxt_pc: U_STATUS,
                               alt_pc: U_STATUS};
            U_PRINT:     w = '{op: OP_ADDR_CUR,  seq: SEQ_NEXT, nxt_pc: U_CELL_RD,
                               alt_pc: U_CELL_RD};
            U_WRCELL:    w = '{op: OP_ADDR_TGT,  seq: SEQ_NEXT, nxt_pc: U_CELL_RD,
                               alt_pc: U_CELL_RD};
            U_CELL_RD:   w = '{op: OP_CELL_RD,   seq: SEQ_NEXT, nxt_pc: U_CELL_PUT,
                               alt_pc: U_CELL_PUT};
            U_CELL_PUT:  w = '{op: OP_CELL_PUT,  seq: SEQ_NEXT, nxt_pc: U_STATUS,
                               alt_pc: U_STATUS};
            U_CLEAR:     w = '{op: OP_CLEAR,     seq: SEQ_NEXT, nxt_pc: U_STATUS,
                               alt_pc: U_STATUS};
            U_STATUS:    w = '{op: OP_STATUS,    seq: SEQ_NEXT, nxt_pc: U_FETCH,
                               alt_pc: U_FETCH};
            U_SCAN_INIT: w = '{op: OP_SCAN_INIT, seq: SEQ_NEXT, nxt_pc: U_SCAN_RD,
                               alt_pc: U_SCAN_RD};
            U_SCAN_RD:   w = '{op: OP_SCAN_RD,   seq: SEQ_NEXT, nxt_pc: U_SCAN_EVAL,
                               alt_pc: U_SCAN_EVAL};
            U_SCAN_EVAL: w = '{op: OP_SCAN_EVAL, seq: SEQ_LOOP, nxt_pc: U_SCAN_RD,
                               alt_pc: U_SCAN_END};
            U_SCAN_END:  w = '{op: OP_SCAN_END,  seq: SEQ_NEXT, nxt_pc: U_FETCH,
                               alt_pc: U_FETCH};
            default:     w = '{op: OP_ACCEPT,    seq: SEQ_DISPATCH, nxt_pc: U_FETCH,
                               alt_pc: U_FETCH};
        endcase
        return w;
    endfunction

endpackage

### hdl/char_lcd_dirty_cell_refresh_top.sv
// Shadow buffer for a multi-panel character display; top level with sequencer and datapath.
// Set cursor, clear and unused codes end in a status transfer; print and write cell read the
// addressed cell first. Update reads and checks the cells one after another through the single
// read port of the cell store. Output stalls hold the control program.
// Synchronous active-low reset: cursor at home, every cell character 0 and unsent;
// the cell store needs no clearing pass, valid bits cover it from the first cycle.
module char_lcd_dirty_cell_refresh_top #(
    parameter int ROWS       = 2,
    parameter int COLS       = 20,
    parameter int PANEL_COLS = 20
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  clcd_pkg::t_in_item  i_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output clcd_pkg::t_out_item o_out
);
    import clcd_pkg::*;

    t_uword   w_uword;
    t_dp_stat w_stat;

    clcd_sequencer u_seq (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_stat (w_stat),
        .o_uword(w_uword)
    );

    clcd_datapath #(
        .ROWS      (ROWS),
        .COLS      (COLS),
        .PANEL_COLS(PANEL_COLS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_uword    (w_uword),
        .o_stat     (w_stat),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out      (o_out)
    );

`ifndef SYNTHESIS
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken while a command is still in progress");

    a_hold_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.hold |=> $stable(w_uword))
        else $error("control step changed during a hold");

    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out.kind != KIND_CELL)) |-> o_out.last)
        else $error("status or empty-update transfer without last");
`endif

endmodule

### hdl/clcd_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; no package needed.
module clcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/clcd_datapath.sv
// Datapath of the shadow buffer: cursor, cell store with valid bits, scan counters,
// pending transfer and output register. Uses clcd_pkg and clcd_ram.
module clcd_datapath #(
    parameter int ROWS       = 2,
    parameter int COLS       = 20,
    parameter int PANEL_COLS = 20
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  clcd_pkg::t_uword   i_uword,
    output clcd_pkg::t_dp_stat o_stat,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  clcd_pkg::t_in_item i_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output clcd_pkg::t_out_item o_out
);
    import clcd_pkg::*;

    localparam int NCELLS = ROWS * COLS;
    localparam int ADDR_W = (NCELLS > 1) ? $clog2(NCELLS) : 1;
    localparam int COL_W  = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam logic [2:0] ROWS_L = 3'(ROWS);
    localparam logic [6:0] COLS_L = 7'(COLS);
    localparam logic [9:0] COLS_M = 10'(COLS);

    t_in_item    r_in;
    logic [6:0]  r_cur_col;
    logic [2:0]  r_cur_row;
    logic [ADDR_W-1:0] r_addr;
    logic        r_err;
    logic        r_skip;
    logic        r_is_print;
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic [4:0]  r_pcol;
    logic [2:0]  r_panel;
    logic        r_chain;
    logic        r_pend_valid;
    t_out_item   r_pend;
    logic        r_out_valid;
    t_out_item   r_out;
    logic [NCELLS-1:0] r_cell_vld;
    logic        r_blank;
    logic        r_rd_vld;

    logic [7:0]  w_rd_data;
    logic [7:0]  w_cell;
    logic [7:0]  w_wdata;
    logic        w_ram_we;
    logic        w_ram_re;
    logic        w_out_free;
    logic        w_emit;
    logic        w_hold;
    logic        w_accept;
    logic        w_last_cell;
    logic        w_col_wrap;
    logic        w_pcol_wrap;
    logic [2:0]  w_sel_row;
    logic [6:0]  w_sel_col;
    logic [9:0]  w_sel_idx;
    logic        w_cur_oob;
    logic        w_tgt_oob_row;
    logic        w_tgt_oob_col;
    logic        w_out_load;
    t_out_item   w_out_item;
    t_out_item   w_cell_item;
    t_out_item   w_status_item;
    t_out_item   w_empty_item;
    t_out_item   w_pend_last;

    clcd_ram #(
        .WIDTH(8),
        .DEPTH(NCELLS)
    ) u_cells (
        .i_clk  (i_clk),
        .i_we   (w_ram_we),
        .i_waddr(r_addr),
        .i_wdata(w_wdata),
        .i_re   (w_ram_re),
        .i_raddr(r_addr),
        .o_rdata(w_rd_data)
    );

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_cell      = r_rd_vld ? w_rd_data : {1'b0, (r_blank ? SPACE_CHAR : 7'd0)};
    assign w_emit      = r_in.force_req || !w_cell[7];
    assign w_last_cell = (r_addr == ADDR_W'(NCELLS - 1));
    assign w_col_wrap  = (r_col == COL_W'(COLS - 1));
    assign w_pcol_wrap = (r_pcol == 5'(PANEL_COLS - 1));

    assign w_sel_row = (i_uword.op == OP_ADDR_CUR) ? r_cur_row : r_in.line;
    assign w_sel_col = (i_uword.op == OP_ADDR_CUR) ? r_cur_col : r_in.column;
    assign w_sel_idx = 10'(w_sel_row) * COLS_M + 10'(w_sel_col);

    assign w_cur_oob     = (r_cur_row >= ROWS_L) || (r_cur_col >= COLS_L);
    assign w_tgt_oob_row = (r_in.line >= ROWS_L);
    assign w_tgt_oob_col = (r_in.column >= COLS_L);

    always_comb begin
        w_cell_item              = '0;
        w_cell_item.kind         = KIND_CELL;
        w_cell_item.move_cursor  = !(r_chain && (r_col != '0));
        w_cell_item.panel        = r_panel;
        w_cell_item.panel_column = r_pcol;
        w_cell_item.row          = 3'(r_row);
        w_cell_item.glyph        = w_cell[6:0];

        w_status_item        = '0;
        w_status_item.kind   = KIND_STATUS;
        w_status_item.status = r_err;
        w_status_item.last   = 1'b1;

        w_empty_item      = '0;
        w_empty_item.kind = KIND_EMPTY;
        w_empty_item.last = 1'b1;

        w_pend_last      = r_pend;
        w_pend_last.last = 1'b1;
    end

    always_comb begin
        w_hold     = 1'b0;
        w_out_load = 1'b0;
        w_out_item = w_status_item;
        case (i_uword.op)
            OP_ACCEPT: begin
                w_hold = !i_in_valid;
            end
            OP_STATUS: begin
                w_hold     = !w_out_free;
                w_out_load = w_out_free;
            end
            OP_SCAN_EVAL: begin
                w_hold     = w_emit && r_pend_valid && !w_out_free;
                w_out_load = w_emit && r_pend_valid && w_out_free;
                w_out_item = r_pend;
            end
            OP_SCAN_END: begin
                w_hold     = !w_out_free;
                w_out_load = w_out_free;
                w_out_item = r_pend_valid ? w_pend_last : w_empty_item;
            end
            default: begin
                w_hold = 1'b0;
            end
        endcase
    end

    assign o_in_ready = (i_uword.op == OP_ACCEPT);
    assign w_accept   = o_in_ready && i_in_valid;

    assign w_ram_re = (i_uword.op == OP_CELL_RD) || (i_uword.op == OP_SCAN_RD);
    assign w_ram_we = ((i_uword.op == OP_CELL_PUT) && !r_skip
                       && (w_cell[6:0] != r_in.char_code))
                   || ((i_uword.op == OP_SCAN_EVAL) && w_emit && !w_hold);
    assign w_wdata  = (i_uword.op == OP_SCAN_EVAL) ? {1'b1, w_cell[6:0]}
                                                    : {1'b0, r_in.char_code};

    always_ff @(posedge i_clk) begin
        if (w_ram_re) begin
            r_rd_vld <= r_cell_vld[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_col    <= '0;
            r_cur_row    <= '0;
            r_cell_vld   <= '0;
            r_blank      <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            case (i_uword.op)
                OP_ACCEPT: begin
                    if (w_accept) begin
                        r_in       <= i_in;
                        r_err      <= 1'b0;
                        r_skip     <= 1'b1;
                        r_is_print <= 1'b0;
                    end
                end
                OP_SETCUR: begin
                    r_cur_col <= r_in.column;
                    r_cur_row <= r_in.line;
                end
                OP_ADDR_CUR: begin
                    r_addr     <= ADDR_W'(w_sel_idx);
                    r_err      <= w_cur_oob;
                    r_skip     <= w_cur_oob;
                    r_is_print <= 1'b1;
                end
                OP_ADDR_TGT: begin
                    r_addr <= ADDR_W'(w_sel_idx);
                    r_err  <= w_tgt_oob_row;
                    r_skip <= w_tgt_oob_row || w_tgt_oob_col;
                end
                OP_CELL_PUT: begin
                    if (w_ram_we) begin
                        r_cell_vld[r_addr] <= 1'b1;
                    end
                    if (r_is_print && !r_err) begin
                        r_cur_col <= r_cur_col + 7'd1;
                    end
                end
                OP_CLEAR: begin
                    r_cell_vld <= '0;
                    r_blank    <= 1'b1;
                    r_cur_col  <= '0;
                    r_cur_row  <= '0;
                end
                OP_SCAN_INIT: begin
                    r_addr       <= '0;
                    r_col        <= '0;
                    r_row        <= '0;
                    r_pcol       <= '0;
                    r_panel      <= '0;
                    r_chain      <= 1'b0;
                    r_pend_valid <= 1'b0;
                end
                OP_SCAN_EVAL: begin
                    if (!w_hold) begin
                        if (w_emit) begin
                            r_cell_vld[r_addr] <= 1'b1;
                            r_pend             <= w_cell_item;
                            r_pend_valid       <= 1'b1;
                        end
                        r_chain <= w_emit && !w_pcol_wrap;
                        r_addr  <= r_addr + ADDR_W'(1);
                        if (w_col_wrap) begin
                            r_col   <= '0;
                            r_row   <= r_row + ROW_W'(1);
                            r_pcol  <= '0;
                            r_panel <= '0;
                        end else begin
                            r_col <= r_col + COL_W'(1);
                            if (w_pcol_wrap) begin
                                r_pcol  <= '0;
                                r_panel <= r_panel + 3'd1;
                            end else begin
                                r_pcol <= r_pcol + 5'd1;
                            end
                        end
                    end
                end
                OP_SCAN_END: begin
                    if (!w_hold) begin
                        r_pend_valid <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out <= w_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign o_stat = '{hold: w_hold, accept: w_accept, last_cell: w_last_cell,
                      mode: i_in.mode};

endmodule

### hdl/clcd_sequencer.sv
// Step counter and control store of the shadow buffer; jumps on command code and scan end.
// Uses clcd_pkg for the program, the step codes and the datapath status.
module clcd_sequencer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  clcd_pkg::t_dp_stat i_stat,
    output clcd_pkg::t_uword   o_uword
);
    import clcd_pkg::*;

    t_upc r_upc;
    t_upc n_upc;
    t_upc w_entry;

    always_comb begin
        unique case (i_stat.mode)
            MODE_SETCUR: w_entry = U_SETCUR;
            MODE_PRINT:  w_entry = U_PRINT;
            MODE_WRCELL: w_entry = U_WRCELL;
            MODE_CLEAR:  w_entry = U_CLEAR;
            MODE_UPDATE: w_entry = U_SCAN_INIT;
            default:     w_entry = U_STATUS;
        endcase
    end

    always_comb begin
        n_upc = r_upc;
        if (!i_stat.hold) begin
            unique case (o_uword.seq)
                SEQ_NEXT:     n_upc = o_uword.nxt_pc;
                SEQ_DISPATCH: n_upc = i_stat.accept ? w_entry : r_upc;
                SEQ_LOOP:     n_upc = i_stat.last_cell ? o_uword.alt_pc : o_uword.nxt_pc;
                default:      n_upc = U_FETCH;
            endcase
        end
    end

    always_comb begin
        o_uword = f_ucode(r_upc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= U_FETCH;
        end else begin
            r_upc <= n_upc;
        end
    end

endmodule

### verif/tb_char_lcd_dirty_cell_refresh_top.sv
// Self-checking testbench for the character display shadow buffer and its refresh scan.
// Depends on clcd_pkg and char_lcd_dirty_cell_refresh_top; predicts every result and
// checks it against the block under random idling on both valid/ready channels.
module tb_char_lcd_dirty_cell_refresh_top;
    timeunit 1ns;
    timeprecision 1ps;

    import clcd_pkg::*;

    localparam int N_ROWS      = 2;
    localparam int N_COLS      = 20;
    localparam int N_PCOLS     = 20;
    localparam int N_CELLS     = N_ROWS * N_COLS;
    localparam int NUM_MODES   = 8;
    localparam int MAX_IDLE    = 13;
    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_LEN    = 300;
    localparam int RAND_ITEMS  = 200;
    localparam int SCAN_CYCLES = 2 * N_CELLS + 3;
    localparam int MAX_REPORTS = 10;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in        = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out;

    logic [6:0] cell_chr [N_CELLS];
    bit         cell_sent[N_CELLS];
    logic [7:0] cur_col;
    logic [7:0] cur_row;

    t_out_item exp_lcd_q[$];

    bit calm        = 1'b0;
    int hold_cycles = 0;
    int err_cnt     = 0;
    int n_items     = 0;
    int n_results   = 0;
    int n_updates   = 0;
    int n_oor       = 0;

    char_lcd_dirty_cell_refresh_top #(
        .ROWS       (N_ROWS),
        .COLS       (N_COLS),
        .PANEL_COLS (N_PCOLS)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int idle_draw();
        if (calm) begin
            return 0;
        end
        return $urandom_range(0, MAX_IDLE);
    endfunction

    function automatic t_in_item mk_cmd(input logic [2:0] mode, input int column,
                                        input int line, input int chr, input bit frc);
        t_in_item it;
        it.mode      = mode;
        it.column    = 7'(column);
        it.line      = 3'(line);
        it.char_code = 7'(chr);
        it.force_req = frc;
        return it;
    endfunction

    function automatic t_in_item noise_cmd();
        return mk_cmd(3'($urandom_range(0, NUM_MODES - 1)), $urandom_range(0, 127),
                      $urandom_range(0, 7), $urandom_range(0, 127), 1'($urandom));
    endfunction

    task automatic store_char(input int r, input int c, input logic [6:0] ch);
        int idx;
        idx = r * N_COLS + c;
        if (idx < N_CELLS && cell_chr[idx] != ch) begin
            cell_chr[idx]  = ch;
            cell_sent[idx] = 1'b0;
        end
    endtask

    task automatic apply_to_shadow(input t_in_item it);
        t_out_item res;
        t_out_item scan[$];
        int        idx, nx, ny, r, c;
        bit        have_next;
        res      = '0;
        res.kind = KIND_STATUS;
        res.last = 1'b1;
        case (it.mode)
            MODE_SETCUR: begin
                cur_col = 8'(it.column);
                cur_row = 8'(it.line);
            end
            MODE_PRINT: begin
                if (cur_row >= N_ROWS || cur_col >= N_COLS) begin
                    res.status = 1'b1;
                end else begin
                    store_char(int'(cur_row), int'(cur_col), it.char_code);
                    cur_col = cur_col + 8'd1;
                end
            end
            MODE_WRCELL: begin
                if (it.line >= N_ROWS) begin
                    res.status = 1'b1;
                end else if (it.column < N_COLS) begin
                    store_char(int'(it.line), int'(it.column), it.char_code);
                end
            end
            MODE_CLEAR: begin
                for (idx = 0; idx < N_CELLS; idx++) begin
                    cell_chr[idx]  = SPACE_CHAR;
                    cell_sent[idx] = 1'b0;
                end
                cur_col = '0;
                cur_row = '0;
            end
            MODE_UPDATE: begin
                n_updates++;
                have_next = 1'b0;
                nx = 0;
                ny = 0;
                for (r = 0; r < N_ROWS; r++) begin
                    for (c = 0; c < N_COLS; c++) begin
                        idx = r * N_COLS + c;
                        if (it.force_req || !cell_sent[idx]) begin
                            res              = '0;
                            res.kind         = KIND_CELL;
                            res.move_cursor  = !(have_next && nx == c && ny == r);
                            res.panel        = 3'(c / N_PCOLS);
                            res.panel_column = 5'(c % N_PCOLS);
                            res.row          = 3'(r);
                            res.glyph        = cell_chr[idx];
                            scan.push_back(res);
                            cell_sent[idx] = 1'b1;
                            ny = r;
                            nx = c + 1;
                            have_next = (nx % N_PCOLS) != 0;
                        end
                    end
                end
                if (scan.size() == 0) begin
                    res      = '0;
                    res.kind = KIND_EMPTY;
                    res.last = 1'b1;
                end else begin
                    res      = scan.pop_back();
                    res.last = 1'b1;
                end
                scan.push_back(res);
            end
            default: begin
            end
        endcase
        if (it.mode != MODE_UPDATE) begin
            if (res.status) begin
                n_oor++;
            end
            scan.push_back(res);
        end
        foreach (scan[k]) begin
            exp_lcd_q.push_back(scan[k]);
        end
    endtask

    task automatic send_cmd(input t_in_item it);
        int gap;
        gap = idle_draw();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in       <= it;
        i_in_valid <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        apply_to_shadow(it);
        n_items++;
    endtask

    task automatic drain_results(input int settle);
        i_in_valid <= 1'b0;
        while (exp_lcd_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic test_reset_state();
        send_cmd(mk_cmd(MODE_UPDATE, 0, 0, 0, 1'b0));
        send_cmd(mk_cmd(MODE_UPDATE, 127, 7, 127, 1'b0));
        drain_results(4);
    endtask

    task automatic test_cursor_print();
        send_cmd(mk_cmd(MODE_PRINT, 0, 0, 65, 1'b0));
        send_cmd(mk_cmd(MODE_PRINT, 0, 0, 127, 1'b0));
        send_cmd(mk_cmd(MODE_SETCUR, N_COLS - 1, N_ROWS - 1, 0, 1'b0));
        send_cmd(mk_cmd(MODE_PRINT, 0, 0, 0, 1'b0));
        send_cmd(mk_cmd(MODE_PRINT, 0, 0, 66, 1'b0));
        send_cmd(mk_cmd(MODE_SETCUR, 127, 7, 0, 1'b0));
        send_cmd(mk_cmd(MODE_PRINT, 0, 0, 67, 1'b0));
        send_cmd(mk_cmd(MODE_SETCUR, 5, N_ROWS, 0, 1'b0));
        send_cmd(mk_cmd(MODE_PRINT, 0, 0, 68, 1'b0));
        drain_results(4);
    endtask

    task automatic test_write_cell();
        send_cmd(mk_cmd(MODE_WRCELL, 3, 1, 120, 1'b0));
        send_cmd(mk_cmd(MODE_WRCELL, 127, 0, 121, 1'b0));
        send_cmd(mk_cmd(MODE_WRCELL, 2, 7, 122, 1'b0));
        send_cmd(mk_cmd(MODE_UPDATE, 0, 0, 0, 1'b0));
        send_cmd(mk_cmd(MODE_WRCELL, 3, 1, 120, 1'b0));
        send_cmd(mk_cmd(MODE_UPDATE, 0, 0, 0, 1'b0));
        send_cmd(mk_cmd(MODE_WRCELL, 3, 1, 0, 1'b0));
        send_cmd(mk_cmd(MODE_WRCELL, N_COLS - 1, 0, 127, 1'b0));
        send_cmd(mk_cmd(MODE_UPDATE, 0, 0, 0, 1'b0));
        drain_results(4);
    endtask

    task automatic test_clear_unused();
        int m;
        send_cmd(mk_cmd(MODE_CLEAR, 127, 7, 127, 1'b1));
        for (m = int'(MODE_UPDATE) + 1; m < NUM_MODES; m++) begin
            send_cmd(mk_cmd(3'(m), $urandom_range(0, 127), $urandom_range(0, 7),
                            $urandom_range(0, 127), 1'($urandom)));
        end
        send_cmd(mk_cmd(MODE_PRINT, 0, 0, 90, 1'b0));
        send_cmd(mk_cmd(MODE_UPDATE, 0, 0, 0, 1'b1));
        send_cmd(mk_cmd(MODE_UPDATE, 0, 0, 0, 1'b0));
        drain_results(4);
    endtask

    task automatic test_backpressure();
        int i;
        hold_cycles = HOLD_LEN;
        send_cmd(mk_cmd(MODE_UPDATE, 0, 0, 0, 1'b1));
        for (i = 0; i < 10; i++) begin
            send_cmd(mk_cmd(MODE_WRCELL, $urandom_range(0, N_COLS - 1),
                            $urandom_range(0, N_ROWS - 1), $urandom_range(0, 127), 1'b0));
        end
        send_cmd(mk_cmd(MODE_UPDATE, 0, 0, 0, 1'b0));
        drain_results(4);
    endtask

    task automatic test_random_traffic();
        int       i, pick;
        t_in_item it;
        for (i = 0; i < RAND_ITEMS; i++) begin
            if (i % 20 == 0) begin
                calm = ($urandom_range(0, 3) == 0);
            end
            pick = $urandom_range(0, 99);
            it   = noise_cmd();
            if (pick < 12) begin
                it.mode = MODE_SETCUR;
                if ($urandom_range(0, 6) != 0) begin
                    it.column = 7'($urandom_range(0, N_COLS - 1));
                    it.line   = 3'($urandom_range(0, N_ROWS - 1));
                end
            end else if (pick < 45) begin
                it.mode = MODE_PRINT;
            end else if (pick < 70) begin
                it.mode = MODE_WRCELL;
                if ($urandom_range(0, 6) != 0) begin
                    it.column = 7'($urandom_range(0, N_COLS - 1));
                    it.line   = 3'($urandom_range(0, N_ROWS - 1));
                end
            end else if (pick < 82) begin
                it.mode      = MODE_UPDATE;
                it.force_req = ($urandom_range(0, 3) == 0);
            end else if (pick < 86) begin
                it.mode = MODE_CLEAR;
            end else if (pick < 90) begin
                it.mode = 3'($urandom_range(int'(MODE_UPDATE) + 1, NUM_MODES - 1));
            end
            send_cmd(it);
        end
        calm = 1'b0;
        drain_results(SCAN_CYCLES + 20);
    endtask

    task automatic report_fault(input string what, input t_out_item want,
                                input t_out_item got);
        err_cnt++;
        if (err_cnt <= MAX_REPORTS) begin
            $display("%0t %s: exp kind=%0d st=%0d mv=%0d pn=%0d pc=%0d row=%0d gl=%0d last=%0d",
                     $realtime, what, want.kind, want.status, want.move_cursor, want.panel,
                     want.panel_column, want.row, want.glyph, want.last);
            $display("%0t %s: got kind=%0d st=%0d mv=%0d pn=%0d pc=%0d row=%0d gl=%0d last=%0d",
                     $realtime, what, got.kind, got.status, got.move_cursor, got.panel,
                     got.panel_column, got.row, got.glyph, got.last);
        end
    endtask

    always @(posedge i_clk) begin : lcd_out_monitor
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_results++;
            if (exp_lcd_q.size() == 0) begin
                report_fault("unexpected transfer", '0, o_out);
            end else begin
                want = exp_lcd_q.pop_front();
                if (o_out.kind !== want.kind || o_out.status !== want.status ||
                    o_out.move_cursor !== want.move_cursor || o_out.panel !== want.panel ||
                    o_out.panel_column !== want.panel_column || o_out.row !== want.row ||
                    o_out.glyph !== want.glyph || o_out.last !== want.last) begin
                    report_fault("mismatch", want, o_out);
                end
            end
        end
    end

    initial begin : lcd_out_sink
        int stall;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) begin
                stall = idle_draw();
            end
            if (hold_cycles > 0) begin
                hold_cycles--;
                i_out_ready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : stall_watchdog
        int quiet;
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet = 0;
        end else begin
            quiet++;
        end
        if (quiet >= STALL_LIMIT) begin
            $display("Watchdog: no transfer for %0d cycles, %0d results outstanding.",
                     quiet, exp_lcd_q.size());
            $display("tb_char_lcd_dirty_cell_refresh_top: FAIL");
            $finish;
        end
    end

    initial begin
        int idx;
        for (idx = 0; idx < N_CELLS; idx++) begin
            cell_chr[idx]  = '0;
            cell_sent[idx] = 1'b0;
        end
        cur_col = '0;
        cur_row = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_cursor_print();
        test_write_cell();
        test_clear_unused();
        test_backpressure();
        test_random_traffic();

        $display("Sent %0d commands, %0d of them screen updates, %0d answered out of range.",
                 n_items, n_updates, n_oor);
        $display("Checked %0d result transfers, %0d mismatches.", n_results, err_cnt);
        if (err_cnt == 0) begin
            $display("tb_char_lcd_dirty_cell_refresh_top: PASS");
        end else begin
            $display("tb_char_lcd_dirty_cell_refresh_top: FAIL");
        end
        $finish;
    end

endmodule
